// ===== sv/tma_pkg.sv =====
// shared types, constants and helpers for the trackball motion accelerator
// no dependencies
package tma_pkg;

	localparam int unsigned CPI_W   = 16;
	localparam int unsigned SCALE_W = 8;
	localparam int unsigned WGT_W   = 8;
	localparam int unsigned MOT_W   = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned NUM_W   = 40;
	localparam int unsigned CNT_W   = 6;

	localparam logic [CPI_W-1:0]   CPI_RESET   = 16'd800;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;
	localparam logic [WGT_W-1:0]   WGT_RESET   = 8'd0;

	localparam logic signed [MOT_W-1:0] SAT_POS = 16'sh7fff;
	localparam logic signed [MOT_W-1:0] SAT_NEG = -16'sh7fff;

	typedef enum logic [IDX_W-1:0] {
		REG_CPI     = 3'd0,
		REG_PSCALE  = 3'd1,
		REG_SSCALE  = 3'd2,
		REG_PWEIGHT = 3'd3,
		REG_SWEIGHT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_M,
		ST_DIV_A,
		ST_DIV_Q,
		ST_DIV_B,
		ST_DONE
	} lane_op_t;

	typedef enum logic [1:0] {
		CT_IDLE,
		CT_RUN,
		CT_OUT
	} ctl_state_t;

	// control bundle from the sequencer to the lanes
	typedef struct packed {
		logic                 start;
		logic [SCALE_W-1:0]   scale;
		logic [WGT_W-1:0]     weight;
	} lane_cmd_t;

	function automatic logic signed [MOT_W-1:0] sat16(input logic signed [NUM_W+1:0] v);
		logic signed [MOT_W-1:0] r;
		if (v > (NUM_W+2)'(signed'(SAT_POS)))
			r = SAT_POS;
		else if (v < (NUM_W+2)'(signed'(SAT_NEG)))
			r = SAT_NEG;
		else
			r = v[MOT_W-1:0];
		return r;
	endfunction

endpackage

// ===== sv/tma_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on tma_pkg
module tma_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tma_pkg::NUM_W-1:0]  num,
	input  logic [tma_pkg::NUM_W-1:0]  den,
	output logic                       busy,
	output logic [tma_pkg::NUM_W-1:0]  quo
);
	import tma_pkg::*;

	localparam int unsigned STEPS = NUM_W;

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [NUM_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [NUM_W:0]   trial;

	assign trial = {rem_q, quo_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= NUM_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[NUM_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

// ===== sv/tma_lane.sv =====
// one axis lane: scale, signed square, normalize and blend
// depends on tma_pkg, tma_divider
module tma_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tma_pkg::lane_cmd_t                cmd,
	input  logic [tma_pkg::CPI_W-1:0]         cpi,
	input  logic signed [tma_pkg::MOT_W-1:0]  raw,
	output logic                              done,
	output logic signed [tma_pkg::NUM_W+1:0]  shaped
);
	import tma_pkg::*;

	lane_op_t           op_q;
	logic [NUM_W-1:0]   m_q;
	logic [MOT_W-1:0]   amag_q;
	logic               neg_q;
	logic [NUM_W-1:0]   blend_q;
	logic [WGT_W-1:0]   w_q;
	logic [SCALE_W-1:0] s_q;
	logic [MOT_W-1:0]   rawmag_q;
	logic               dv_start;
	logic [NUM_W-1:0]   dv_num;
	logic [NUM_W-1:0]   dv_den;
	logic               dv_busy;
	logic [NUM_W-1:0]   dv_quo;
	logic               issued_q;
	logic [MOT_W-1:0]   rawmag;

	assign rawmag = raw[MOT_W-1] ? MOT_W'(-raw) : raw;

	tma_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dv_start),
		.num   (dv_num),
		.den   (dv_den),
		.busy  (dv_busy),
		.quo   (dv_quo)
	);

	always_comb begin
		dv_start = (op_q != ST_IDLE) && (op_q != ST_DONE) && !issued_q;
		dv_num   = '0;
		dv_den   = NUM_W'(1);
		case (op_q)
			ST_DIV_M: begin
				dv_num = NUM_W'(cpi);
				dv_den = NUM_W'(s_q);
			end
			ST_DIV_A: begin
				dv_num = NUM_W'(rawmag_q);
				dv_den = NUM_W'(s_q);
			end
			ST_DIV_Q: begin
				dv_num = NUM_W'(amag_q) * NUM_W'(amag_q);
				dv_den = (m_q == '0) ? NUM_W'(1) : m_q;
			end
			ST_DIV_B: begin
				dv_num = blend_q;
				dv_den = NUM_W'(w_q) + NUM_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= ST_IDLE;
			issued_q <= 1'b0;
		end else if (cmd.start) begin
			op_q     <= ST_DIV_M;
			issued_q <= 1'b0;
		end else if (dv_start) begin
			issued_q <= 1'b1;
		end else if (issued_q && !dv_busy) begin
			issued_q <= 1'b0;
			case (op_q)
				ST_DIV_M: op_q <= ST_DIV_A;
				ST_DIV_A: op_q <= ST_DIV_Q;
				ST_DIV_Q: op_q <= ST_DIV_B;
				ST_DIV_B: op_q <= ST_DONE;
				default:  op_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q      <= (cmd.scale == '0) ? SCALE_W'(1) : cmd.scale;
			w_q      <= cmd.weight;
			rawmag_q <= rawmag;
			neg_q    <= raw[MOT_W-1];
		end else if (issued_q && !dv_busy) begin
			case (op_q)
				ST_DIV_M: m_q <= dv_quo;
				ST_DIV_A: amag_q <= dv_quo[MOT_W-1:0];
				ST_DIV_Q: begin
					// a and q share the sign, so the blend is done on magnitudes
					blend_q <= NUM_W'(amag_q)
						+ NUM_W'(w_q) * ((m_q == '0) ? NUM_W'(0) : dv_quo);
				end
				ST_DIV_B: blend_q <= dv_quo;
				default: ;
			endcase
		end
	end

	assign done   = (op_q == ST_DONE);
	assign shaped = neg_q ? -(NUM_W+2)'(signed'({2'b00, blend_q}))
	                      : (NUM_W+2)'(signed'({2'b00, blend_q}));
endmodule

// ===== sv/tma_merge.sv =====
// merge stage: axis lock, routing, saturation and accumulation
// depends on tma_pkg
module tma_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              valid,
	input  logic                              scroll,
	input  logic                              lock,
	input  logic                              taken,
	input  logic                              cfg,
	input  logic signed [tma_pkg::NUM_W+1:0]  x,
	input  logic signed [tma_pkg::NUM_W+1:0]  y,
	output logic signed [tma_pkg::MOT_W-1:0]  acc_px,
	output logic signed [tma_pkg::MOT_W-1:0]  acc_py,
	output logic signed [tma_pkg::MOT_W-1:0]  acc_wx,
	output logic signed [tma_pkg::MOT_W-1:0]  acc_wy
);
	import tma_pkg::*;

	logic signed [MOT_W-1:0] acc_q [4];
	logic signed [MOT_W-1:0] add   [4];
	logic signed [NUM_W+1:0] lx, ly, xa, ya;
	logic signed [MOT_W-1:0] sx, sy;

	always_comb begin
		xa = (x < 0) ? -x : x;
		ya = (y < 0) ? -y : y;
		lx = x;
		ly = y;
		if (lock) begin
			if (xa < ya)
				lx = '0;
			else
				ly = '0;
		end
		sx = sat16(lx);
		sy = sat16(ly);
		for (int i = 0; i < 4; i++)
			add[i] = '0;
		if (valid) begin
			if (scroll) begin
				add[2] = sx;
				add[3] = -sy;
			end else begin
				add[0] = sx;
				add[1] = sy;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				acc_q[i] <= '0;
		end else if (load) begin
			for (int i = 0; i < 4; i++) begin
				if (cfg)
					acc_q[i] <= '0;
				else
					acc_q[i] <= sat16((taken ? '0 : (NUM_W+2)'(acc_q[i]))
						+ (NUM_W+2)'(add[i]));
			end
		end
	end

	assign acc_px = acc_q[0];
	assign acc_py = acc_q[1];
	assign acc_wx = acc_q[2];
	assign acc_wy = acc_q[3];
endmodule

// ===== sv/trackball_motion_accelerator_core.sv =====
// trackball motion accelerator top level: one lane per axis plus merge stage
// a motion item runs four serial divisions per lane plus issue and load; setup clear
// and no-motion items skip the lanes and go straight to the load
// one item at a time: no new item is accepted until the result is taken
// reset: arst_n clears accumulators, config registers to defaults and control
// depends on tma_pkg, tma_lane, tma_merge
module trackball_motion_accelerator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tma_pkg::MOT_W-1:0]  raw_dx,
	input  logic signed [tma_pkg::MOT_W-1:0]  raw_dy,
	input  logic                              motion_valid,
	input  logic                              scroll_mode,
	input  logic                              axis_lock,
	input  logic                              report_taken,
	input  logic                              setup_clear,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tma_pkg::MOT_W-1:0]  pointer_x,
	output logic signed [tma_pkg::MOT_W-1:0]  pointer_y,
	output logic signed [tma_pkg::MOT_W-1:0]  wheel_x,
	output logic signed [tma_pkg::MOT_W-1:0]  wheel_y,
	output logic                              moved,
	input  logic                              cfg_we,
	input  logic [tma_pkg::IDX_W-1:0]         cfg_index,
	input  logic [tma_pkg::CFG_W-1:0]         cfg_data
);
	import tma_pkg::*;

	// configuration registers
	logic [CPI_W-1:0]   cpi_q;
	logic [SCALE_W-1:0] pscale_q, sscale_q;
	logic [WGT_W-1:0]   pwgt_q, swgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpi_q    <= CPI_RESET;
			pscale_q <= SCALE_RESET;
			sscale_q <= SCALE_RESET;
			pwgt_q   <= WGT_RESET;
			swgt_q   <= WGT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_CPI:     cpi_q    <= cfg_data;
				REG_PSCALE:  pscale_q <= cfg_data[SCALE_W-1:0];
				REG_SSCALE:  sscale_q <= cfg_data[SCALE_W-1:0];
				REG_PWEIGHT: pwgt_q   <= cfg_data[WGT_W-1:0];
				REG_SWEIGHT: swgt_q   <= cfg_data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic signed [MOT_W-1:0] dx_q, dy_q;
	logic valid_q, scroll_q, lock_q, taken_q, cfgm_q;

	ctl_state_t st_q, st_d;
	logic       accept;
	logic       load;
	logic       kick_q;
	lane_cmd_t  cmd;
	logic       done_x, done_y;
	logic signed [NUM_W+1:0] shp_x, shp_y;

	assign accept = in_valid && in_ready;

	// lanes start the cycle after accept, once operands are registered
	assign cmd.start  = kick_q;
	assign cmd.scale  = scroll_q ? sscale_q : pscale_q;
	assign cmd.weight = scroll_q ? swgt_q : pwgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= CT_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		load     = 1'b0;
		case (st_q)
			CT_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					st_d = CT_RUN;
			end
			CT_RUN: begin
				// setup clear and no-motion items skip the lanes
				if (!kick_q && (cfgm_q || !valid_q || (done_x && done_y))) begin
					load = 1'b1;
					st_d = CT_OUT;
				end
			end
			CT_OUT: begin
				if (out_ready)
					st_d = CT_IDLE;
			end
			default: st_d = CT_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q     <= raw_dx;
			dy_q     <= raw_dy;
			valid_q  <= motion_valid;
			scroll_q <= scroll_mode;
			lock_q   <= axis_lock;
			taken_q  <= report_taken;
			cfgm_q   <= setup_clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kick_q <= 1'b0;
		else
			kick_q <= accept && motion_valid && !setup_clear;
	end

	tma_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cpi(cpi_q), .raw(dx_q),
		.done(done_x), .shaped(shp_x)
	);

	tma_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cpi(cpi_q), .raw(dy_q),
		.done(done_y), .shaped(shp_y)
	);

	tma_merge u_merge (
		.clk(clk), .arst_n(arst_n), .load(load),
		.valid(valid_q), .scroll(scroll_q), .lock(lock_q),
		.taken(taken_q), .cfg(cfgm_q), .x(shp_x), .y(shp_y),
		.acc_px(pointer_x), .acc_py(pointer_y),
		.acc_wx(wheel_x), .acc_wy(wheel_y)
	);

	assign out_valid = (st_q == CT_OUT);
	assign moved     = valid_q && !cfgm_q;

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != CT_IDLE) |-> !in_ready) else $error("ready while busy");
	a_load_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid) else $error("result not shown after load");
	a_cfg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfgm_q) |-> (pointer_x == 0 && wheel_y == 0 && !moved))
		else $error("setup clear result not zero");
`endif
endmodule

// ===== dv/tb_trackball_motion_accelerator_core.sv =====
// testbench for trackball_motion_accelerator_core: directed table, then random phases
// with their own register settings, each result checked against a typed-in expectation or an in-bench predictor
// depends on tma_pkg and trackball_motion_accelerator_core
`timescale 1ns / 1ps

module tb_trackball_motion_accelerator_core;
	import tma_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RAND_ITEMS  = 1630;
	localparam int NUM_PHASES  = 6;

	typedef struct {
		logic signed [MOT_W-1:0] dx;
		logic signed [MOT_W-1:0] dy;
		logic mv;
		logic sc;
		logic lk;
		logic tk;
		logic cm;
	} report_t;

	typedef struct {
		logic signed [MOT_W-1:0] px;
		logic signed [MOT_W-1:0] py;
		logic signed [MOT_W-1:0] wx;
		logic signed [MOT_W-1:0] wy;
		logic mv;
	} motion_t;

	// typed-in expectation that rides along with each sent item
	typedef struct {
		bit      fixed;
		motion_t want;
	} tag_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [MOT_W-1:0] raw_dx = '0;
	logic signed [MOT_W-1:0] raw_dy = '0;
	logic motion_valid = 1'b0;
	logic scroll_mode = 1'b0;
	logic axis_lock = 1'b0;
	logic report_taken = 1'b0;
	logic setup_clear = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [MOT_W-1:0] pointer_x;
	logic signed [MOT_W-1:0] pointer_y;
	logic signed [MOT_W-1:0] wheel_x;
	logic signed [MOT_W-1:0] wheel_y;
	logic moved;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	trackball_motion_accelerator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_dx(raw_dx), .raw_dy(raw_dy), .motion_valid(motion_valid),
		.scroll_mode(scroll_mode), .axis_lock(axis_lock),
		.report_taken(report_taken), .setup_clear(setup_clear),
		.out_valid(out_valid), .out_ready(out_ready),
		.pointer_x(pointer_x), .pointer_y(pointer_y),
		.wheel_x(wheel_x), .wheel_y(wheel_y), .moved(moved),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// predictor copy of registers and accumulators
	longint unsigned cpi_r, psc_r, ssc_r, pwt_r, swt_r;
	longint acc_r [4];

	motion_t  motion_q [$];
	tag_t     tag_q [$];
	report_t  table_q [$];
	tag_t     table_tag_q [$];
	int       err_cnt = 0;
	int       cycle_cnt = 0;
	int       seen_cnt = 0;
	bit       quiet = 1'b0;
	int       rx_stall = 0;

	function automatic longint sat_motion(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32767)
			return -32767;
		return v;
	endfunction

	// linear part blended with signed square over the normalizer, all truncating
	function automatic longint shape_axis(input longint raw, input longint scale,
			input longint norm, input longint w);
		longint a;
		longint q;
		longint sq;
		a = raw / scale;
		q = 0;
		if (norm != 0) begin
			sq = a * a;
			if (a < 0)
				sq = -sq;
			q = sq / norm;
		end
		return (a + w * q) / (1 + w);
	endfunction

	function automatic motion_t predict_motion(input report_t r);
		motion_t res;
		longint add [4];
		longint scale, w, norm, x, y, xa, ya;
		int i;
		for (i = 0; i < 4; i++)
			add[i] = 0;
		if (r.cm) begin
			for (i = 0; i < 4; i++)
				acc_r[i] = 0;
			res = '{px: '0, py: '0, wx: '0, wy: '0, mv: 1'b0};
			return res;
		end
		if (r.mv) begin
			scale = r.sc ? ssc_r : psc_r;
			w = r.sc ? swt_r : pwt_r;
			// a zero divisor behaves as one
			if (scale == 0)
				scale = 1;
			norm = cpi_r / scale;
			x = shape_axis(longint'(r.dx), scale, norm, w);
			y = shape_axis(longint'(r.dy), scale, norm, w);
			if (r.lk) begin
				xa = x < 0 ? -x : x;
				ya = y < 0 ? -y : y;
				// on a tie x survives
				if (xa < ya)
					x = 0;
				else
					y = 0;
			end
			if (r.sc) begin
				add[2] = sat_motion(x);
				add[3] = sat_motion(-y);
			end else begin
				add[0] = sat_motion(x);
				add[1] = sat_motion(y);
			end
		end
		if (r.tk)
			for (i = 0; i < 4; i++)
				acc_r[i] = 0;
		for (i = 0; i < 4; i++)
			acc_r[i] = sat_motion(acc_r[i] + add[i]);
		res.px = acc_r[0][MOT_W-1:0];
		res.py = acc_r[1][MOT_W-1:0];
		res.wx = acc_r[2][MOT_W-1:0];
		res.wy = acc_r[3][MOT_W-1:0];
		res.mv = r.mv;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
		err_cnt++;
	endtask

	// result checker, item acceptance, cycle limit
	always @(posedge clk) begin
		report_t r;
		motion_t exp_m;
		motion_t pred;
		tag_t    tg;
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (motion_q.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				exp_m = motion_q.pop_front();
				seen_cnt++;
				if (pointer_x !== exp_m.px) report_mismatch("pointer_x", pointer_x, exp_m.px);
				if (pointer_y !== exp_m.py) report_mismatch("pointer_y", pointer_y, exp_m.py);
				if (wheel_x !== exp_m.wx) report_mismatch("wheel_x", wheel_x, exp_m.wx);
				if (wheel_y !== exp_m.wy) report_mismatch("wheel_y", wheel_y, exp_m.wy);
				if (moved !== exp_m.mv) report_mismatch("moved", moved, exp_m.mv);
			end
		end
		if (arst_n && in_valid && in_ready) begin
			r = '{dx: raw_dx, dy: raw_dy, mv: motion_valid, sc: scroll_mode,
				lk: axis_lock, tk: report_taken, cm: setup_clear};
			// predictor always runs so its accumulators follow the block
			pred = predict_motion(r);
			tg = tag_q.pop_front();
			if (tg.fixed)
				motion_q.push_back(tg.want);
			else
				motion_q.push_back(pred);
		end
	end

	// receiver: random stall bursts, none once quiet
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			rx_stall <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// one register write, mirrored into the predictor; upper bits of narrow
	// registers carry noise that the block must drop
	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		logic [CFG_W-1:0] d;
		d = CFG_W'(val);
		if (idx != REG_CPI)
			d[CFG_W-1:8] = 8'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_CPI:     cpi_r = d;
			REG_PSCALE:  psc_r = d[7:0];
			REG_SSCALE:  ssc_r = d[7:0];
			REG_PWEIGHT: pwt_r = d[7:0];
			REG_SWEIGHT: swt_r = d[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input int unsigned cpi, input int unsigned psc,
			input int unsigned ssc, input int unsigned pwt, input int unsigned swt);
		write_reg(REG_CPI, cpi);
		write_reg(REG_PSCALE, psc);
		write_reg(REG_SSCALE, ssc);
		write_reg(REG_PWEIGHT, pwt);
		write_reg(REG_SWEIGHT, swt);
	endtask

	// hold the sender until every expected result has drained
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (motion_q.size() != 0 || tag_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// present one item and wait for its handshake; leaves valid high
	task automatic send_item(input report_t r, input tag_t tg);
		tag_q.push_back(tg);
		in_valid <= 1'b1;
		raw_dx <= r.dx;
		raw_dy <= r.dy;
		motion_valid <= r.mv;
		scroll_mode <= r.sc;
		axis_lock <= r.lk;
		report_taken <= r.tk;
		setup_clear <= r.cm;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic sender_gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic add_row(input int dx, input int dy, input logic mv, input logic sc,
			input logic lk, input logic tk, input logic cm, input bit fixed,
			input int px, input int py, input int wx, input int wy, input logic mo);
		report_t r;
		tag_t tg;
		r = '{dx: dx[15:0], dy: dy[15:0], mv: mv, sc: sc, lk: lk, tk: tk, cm: cm};
		tg.fixed = fixed;
		tg.want = '{px: px[15:0], py: py[15:0], wx: wx[15:0], wy: wy[15:0], mv: mo};
		table_q.push_back(r);
		table_tag_q.push_back(tg);
	endtask

	function automatic logic signed [MOT_W-1:0] rand_axis();
		int pick;
		case ($urandom_range(0, 3))
			0: return MOT_W'($urandom_range(0, 600) - 300);
			1: return MOT_W'($urandom);
			2: begin
				pick = $urandom_range(0, 5);
				case (pick)
					0: return 16'sh8000;
					1: return -16'sh7fff;
					2: return 16'sh7fff;
					3: return 16'sh0000;
					4: return -16'sh0001;
					default: return 16'sh0001;
				endcase
			end
			default: return MOT_W'($urandom_range(0, 6000) - 3000);
		endcase
	endfunction

	function automatic report_t rand_report();
		report_t r;
		r.dx = rand_axis();
		r.dy = rand_axis();
		r.mv = $urandom_range(0, 99) < 85;
		r.sc = 1'($urandom_range(0, 1));
		r.lk = $urandom_range(0, 99) < 30;
		r.tk = $urandom_range(0, 99) < 20;
		r.cm = $urandom_range(0, 99) < 3;
		return r;
	endfunction

	// phase settings: normal, zero normalizer, maximum everything but the scroll weight, zero scale,
	// normalizer rounding to zero, then fully random
	int unsigned ph_cpi [NUM_PHASES] = '{800, 0, 65535, 65535, 100, 0};
	int unsigned ph_psc [NUM_PHASES] = '{1, 3, 255, 0, 200, 0};
	int unsigned ph_ssc [NUM_PHASES] = '{1, 7, 255, 0, 150, 0};
	int unsigned ph_pwt [NUM_PHASES] = '{128, 255, 255, 1, 40, 0};
	int unsigned ph_swt [NUM_PHASES] = '{64, 255, 0, 200, 90, 0};

	initial begin
		report_t r;
		tag_t    no_tag;
		int      ph, n, per_phase;
		cpi_r = CPI_RESET;
		psc_r = SCALE_RESET;
		ssc_r = SCALE_RESET;
		pwt_r = WGT_RESET;
		swt_r = WGT_RESET;
		for (int i = 0; i < 4; i++)
			acc_r[i] = 0;
		no_tag.fixed = 1'b0;
		no_tag.want = '{px: '0, py: '0, wx: '0, wy: '0, mv: 1'b0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under reset settings: linear pass-through, no blend
		add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);               // quiet after reset
		add_row(100, -50, 1, 0, 0, 1, 0, 1, 100, -50, 0, 0, 1);
		add_row(20, 30, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);             // accumulate
		add_row(7, 7, 1, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0);               // setup clear
		add_row(32767, -32768, 1, 0, 0, 1, 0, 1, 32767, -32767, 0, 0, 1);
		add_row(32767, -32768, 1, 0, 0, 0, 0, 1, 32767, -32767, 0, 0, 1); // stays saturated
		add_row(-1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);              // backs off saturation
		add_row(-32768, 32767, 1, 1, 0, 1, 0, 1, 0, 0, -32767, -32767, 1); // scroll negates y
		add_row(5, -5, 1, 0, 1, 1, 0, 1, 5, 0, 0, 0, 1);              // lock tie keeps x
		add_row(3, -9, 1, 0, 1, 1, 0, 1, 0, -9, 0, 0, 1);             // lock keeps y
		add_row(-9, 3, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(1234, 4321, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);         // no motion: holds
		add_row(1234, 4321, 0, 1, 1, 1, 0, 1, 0, 0, 0, 0, 0);         // no motion, cleared
		add_row(-32768, -32768, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(32767, 32767, 1, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0);
		while (table_q.size() != 0) begin
			send_item(table_q.pop_front(), table_tag_q.pop_front());
			sender_gap();
		end
		drain();

		// random phases, each with its own register settings
		per_phase = RAND_ITEMS / NUM_PHASES;
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == NUM_PHASES - 1)
				write_all($urandom_range(0, 65535), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			else
				write_all(ph_cpi[ph], ph_psc[ph], ph_ssc[ph], ph_pwt[ph], ph_swt[ph]);
			for (n = 0; n < per_phase; n++) begin
				// final stretch runs with no idling on either side
				if (ph == NUM_PHASES - 1 && n == per_phase / 2)
					quiet = 1'b1;
				r = rand_report();
				send_item(r, no_tag);
				if (n == per_phase / 3)
					drain();
				else
					sender_gap();
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("ran %0d results across %0d register settings, with saturation, lock,",
			seen_cnt, NUM_PHASES + 1);
		$display("scroll, clear and setup-clear cases under random stalls");
		if (err_cnt == 0 && motion_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("errors %0d, left over %0d", err_cnt, motion_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/tma_pkg.sv
sv/tma_divider.sv
sv/tma_lane.sv
sv/tma_merge.sv
sv/trackball_motion_accelerator_core.sv
dv/tb_trackball_motion_accelerator_core.sv
